### hdl/approx_plane_dedup_table_core_assert.svh
// Assertion macros for the plane de-duplication table.
// Needs nothing else; included by the top level just before its checks.
`ifndef APPROX_PLANE_DEDUP_TABLE_CORE_ASSERT_SVH
`define APPROX_PLANE_DEDUP_TABLE_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define APDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define APDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/apdt_pkg.sv
// Shared types and constants for the plane de-duplication table.
// No dependencies; imported by every module of the block.
package apdt_pkg;

  localparam int unsigned MAX_PLANES_DEF = 64;

  localparam logic signed [15:0] NORMAL_THR_RST = 16'sd30792;
  localparam logic [30:0]        DIST_THR_RST   = 31'd25600;

  // Register indexes (paddr[2])
  localparam logic REG_IDX_NORMAL = 1'b0;
  localparam logic REG_IDX_DIST   = 1'b1;

  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [31:0] off;
  } plane_t;

endpackage

### hdl/apdt_cell.sv
// One storage cell of the plane ring: holds a single plane.
// Depends on apdt_pkg for the plane type.
module apdt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            load_i,
  input  apdt_pkg::plane_t next_i,
  input  apdt_pkg::plane_t query_i,
  output apdt_pkg::plane_t plane_o
);
  import apdt_pkg::*;

  plane_t plane_q;

  // Append takes priority; otherwise take the neighbour's plane
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plane_q <= query_i;
    end else if (shift_i) begin
      plane_q <= next_i;
    end
  end

  assign plane_o = plane_q;

endmodule

### hdl/apdt_cmp.sv
// Two-stage plane comparator: offset distance and normal dot product.
// Depends on apdt_pkg for the plane type.
module apdt_cmp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  apdt_pkg::plane_t    stored_i,
  input  apdt_pkg::plane_t    query_i,
  input  logic signed [15:0]  normal_thr_i,
  input  logic [30:0]         dist_thr_i,
  output logic                match_o
);
  import apdt_pkg::*;

  logic signed [31:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [31:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic               near_d, near_q;
  logic               valid_q;
  logic signed [33:0] dot;
  logic signed [33:0] limit;
  logic               match_d, match_q;

  assign prod_x_d = stored_i.nx * query_i.nx;
  assign prod_y_d = stored_i.ny * query_i.ny;
  assign prod_z_d = stored_i.nz * query_i.nz;

  assign diff   = 33'(stored_i.off) - 33'(query_i.off);
  assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
  assign near_d = mag < {2'b00, dist_thr_i};

  assign dot     = 34'(prod_x_q) + 34'(prod_y_q) + 34'(prod_z_q);
  assign limit   = {{3{normal_thr_i[15]}}, normal_thr_i, 15'b0};
  assign match_d = valid_q && near_q && (dot > limit);

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    prod_z_q <= prod_z_d;
    near_q   <= near_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

### hdl/approx_plane_dedup_table_core.sv
// Top level of the plane de-duplication table: ring of plane cells,
// comparator, control sequencer and APB registers. Uses apdt_pkg,
// apdt_cell, apdt_cmp and the assertion macro header.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | command, normal_x/y/z, offset
//   out     | output    | out_valid_o/out_stall_i | status, stored_count
//   apb     | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// An offered plane is checked over one full ring revolution, then passes the
// comparator pipeline; its result is registered and the block returns to idle
// before the next acceptance. A clear skips the scan. Reset empties the list;
// stored planes are not reset.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits in its final cycle until the register frees.
module approx_plane_dedup_table_core #(
  parameter int unsigned MaxPlanes = apdt_pkg::MAX_PLANES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [31:0] plane_offset_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [6:0]         stored_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import apdt_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPlanes + 1);
  localparam int unsigned StepW = $clog2(MaxPlanes + 3);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               dup_q, dup_d;
  logic               cmd_q;
  plane_t             query_q;
  logic signed [15:0] normal_thr_q;
  logic [30:0]        dist_thr_q;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [6:0]         count_out_q;

  logic    in_accept;
  logic    cfg_write;
  logic    rotate;
  logic    cmp_valid;
  logic    match;
  logic    out_load;
  logic    append;
  plane_t  ring [MaxPlanes];

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_thr_q <= NORMAL_THR_RST;
      dist_thr_q   <= DIST_THR_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_IDX_NORMAL: normal_thr_q <= pwdata[15:0];
        REG_IDX_DIST:   dist_thr_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDX_NORMAL: prdata = {{16{normal_thr_q[15]}}, normal_thr_q};
      REG_IDX_DIST:   prdata = {1'b0, dist_thr_q};
      default:        prdata = '0;
    endcase
  end

  // Ring of plane cells; cell 0 feeds the comparator
  assign rotate    = (state_q == S_SCAN) && (step_q < StepW'(MaxPlanes));
  assign cmp_valid = (state_q == S_SCAN) && (step_q < StepW'(count_q));

  for (genvar k = 0; k < MaxPlanes; k++) begin : g_cell
    apdt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (rotate),
      .load_i  (append && (count_q == CntW'(k))),
      .next_i  (ring[(k + 1) % MaxPlanes]),
      .query_i (query_q),
      .plane_o (ring[k])
    );
  end

  apdt_cmp u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (cmp_valid),
    .stored_i     (ring[0]),
    .query_i      (query_q),
    .normal_thr_i (normal_thr_q),
    .dist_thr_i   (dist_thr_q),
    .match_o      (match)
  );

  // Sequencer
  assign out_load = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);
  assign append   = out_load && (cmd_q == CMD_OFFER) && !dup_q &&
                    (count_q != CntW'(MaxPlanes));

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    dup_d    = dup_q;
    count_d  = count_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          step_d  = '0;
          dup_d   = 1'b0;
          state_d = (command_i == CMD_CLEAR) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        dup_d  = dup_q | match;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(MaxPlanes + 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
          if (cmd_q == CMD_CLEAR) begin
            status_d = ST_CLEARED;
            count_d  = '0;
          end else if (dup_q) begin
            status_d = ST_DUP;
          end else if (count_q == CntW'(MaxPlanes)) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_ADDED;
            count_d  = count_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      dup_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      dup_q       <= dup_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the query and the result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q       <= command_i;
      query_q.nx  <= normal_x_i;
      query_q.ny  <= normal_y_i;
      query_q.nz  <= normal_z_i;
      query_q.off <= plane_offset_i;
    end
    if (out_load) begin
      status_q    <= status_d;
      count_out_q <= 7'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign stored_count_o = count_out_q;

`include "approx_plane_dedup_table_core_assert.svh"

  `APDT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, in_stall_o, "accept did not start work")
  `APDT_ASSERT_NEXT(a_scan_count_hold, clk_i, rst_ni, (state_q == S_SCAN), (count_q == $past(count_q)), "count changed during scan")
  `APDT_ASSERT_NEXT(a_append_count, clk_i, rst_ni, append, (count_q == $past(count_q) + 1'b1), "append did not advance count")
  `APDT_ASSERT_SAME(a_count_bound, clk_i, rst_ni, out_valid_q, (count_q <= CntW'(MaxPlanes)), "count beyond table size")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for approx_plane_dedup_table_core: planes and clears go in over
// valid/stall with random idling, and each result is checked against a behavioural table.
// Needs apdt_pkg and the block's RTL; nothing else.
module testbench;
  import apdt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = MAX_PLANES_DEF;
  localparam int          STUCK_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = TABLE_DEPTH + 8;

  localparam logic signed [15:0] NRM_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] NRM_MIN  = 16'sh8000;
  localparam logic signed [31:0] OFF_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] OFF_MIN  = 32'sh8000_0000;
  localparam logic [30:0]        DIST_MAX = 31'h7FFF_FFFF;

  typedef struct {
    status_e    status;
    logic [6:0] count;
  } dedup_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               command_i      = CMD_OFFER;
  logic signed [15:0] normal_x_i     = '0;
  logic signed [15:0] normal_y_i     = '0;
  logic signed [15:0] normal_z_i     = '0;
  logic signed [31:0] plane_offset_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [1:0]         status_o;
  logic [6:0]         stored_count_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [2:0]         paddr          = '0;
  logic [31:0]        pwdata         = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Behavioural copy of the table and its settings
  plane_t             plane_bank [TABLE_DEPTH];
  int unsigned        bank_fill    = 0;
  logic signed [15:0] cos_limit    = NORMAL_THR_RST;
  logic [30:0]        offset_limit = DIST_THR_RST;

  dedup_result_t pending_results[$];
  dedup_result_t due_result;
  plane_t        recent_planes[$];
  int            status_tally [4];
  int            items_sent;
  int            reg_writes;
  int            fail_count;
  int            stuck_cycles;
  int            stall_left;
  int            calm_left;
  int unsigned   clear_odds   = 3;
  logic          steady       = 1'b0;
  logic          sender_idles = 1'b1;

  approx_plane_dedup_table_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .plane_offset_i (plane_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .stored_count_o (stored_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic dedup_result_t predict_dedup(input logic cmd, input plane_t p);
    dedup_result_t r;
    logic          hit;
    longint        gap;
    longint        dot;
    hit = 1'b0;
    if (cmd == CMD_CLEAR) begin
      bank_fill = 0;
      r.status  = ST_CLEARED;
    end else begin
      for (int i = 0; i < bank_fill; i++) begin
        gap = longint'(plane_bank[i].off) - longint'(p.off);
        if (gap < 0) gap = -gap;
        dot = longint'(plane_bank[i].nx) * longint'(p.nx)
            + longint'(plane_bank[i].ny) * longint'(p.ny)
            + longint'(plane_bank[i].nz) * longint'(p.nz);
        if (gap < longint'(offset_limit) && dot > longint'(cos_limit) * 32768) hit = 1'b1;
      end
      if (hit) begin
        r.status = ST_DUP;
      end else if (bank_fill >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        plane_bank[bank_fill] = p;
        bank_fill++;
        r.status = ST_ADDED;
      end
    end
    r.count = bank_fill[6:0];
    status_tally[r.status]++;
    return r;
  endfunction

  function automatic plane_t mk_plane(input logic signed [15:0] nx, input logic signed [15:0] ny,
                                      input logic signed [15:0] nz, input logic signed [31:0] off);
    plane_t p;
    p.nx  = nx;
    p.ny  = ny;
    p.nz  = nz;
    p.off = off;
    return p;
  endfunction

  function automatic longint jitter(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // Roughly unit normal in a random direction, offset over a random span
  function automatic plane_t fresh_plane();
    plane_t p;
    real    vx, vy, vz, len;
    vx  = real'(int'($urandom_range(0, 2000)) - 1000);
    vy  = real'(int'($urandom_range(0, 2000)) - 1000);
    vz  = real'(int'($urandom_range(0, 2000)) - 1000);
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0) begin
      vx  = 1000.0;
      len = 1000.0;
    end
    p.nx  = 16'($rtoi(32767.0 * vx / len));
    p.ny  = 16'($rtoi(32767.0 * vy / len));
    p.nz  = 16'($rtoi(32767.0 * vz / len));
    p.off = $signed($urandom()) >>> $urandom_range(0, 16);
    return p;
  endfunction

  // Plane close to an earlier one, often straddling the tolerances
  function automatic plane_t nearby_plane(input plane_t h);
    plane_t      p;
    int unsigned tilt;
    int unsigned reach;
    p    = h;
    tilt = (1 << $urandom_range(0, 13)) - 1;
    if ($urandom_range(0, 3) != 0) begin
      p.nx = 16'(longint'(h.nx) + jitter(tilt));
      p.ny = 16'(longint'(h.ny) + jitter(tilt));
      p.nz = 16'(longint'(h.nz) + jitter(tilt));
    end
    if ($urandom_range(0, 9) == 0) begin
      p.nx = -p.nx;
      p.ny = -p.ny;
      p.nz = -p.nz;
    end
    reach = (offset_limit > 31'd268435456) ? 32'd536870912 : 2 * offset_limit + 256;
    case ($urandom_range(0, 5))
      0: p.off = h.off;
      1: p.off = 32'(longint'(h.off) + longint'(offset_limit));
      2: p.off = 32'(longint'(h.off) - longint'(offset_limit) + 1);
      default: p.off = 32'(longint'(h.off) + jitter(reach));
    endcase
    return p;
  endfunction

  task automatic send_request(input logic cmd, input plane_t p);
    dedup_result_t r;
    if (sender_idles && !steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    normal_x_i     <= p.nx;
    normal_y_i     <= p.ny;
    normal_z_i     <= p.nz;
    plane_offset_i <= p.off;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_dedup(cmd, p);
    pending_results.push_back(r);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_IDX_NORMAL) cos_limit = value[15:0];
    else offset_limit = value[30:0];
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input logic signed [15:0] cos_val, input logic [30:0] off_val);
    settle_block();
    write_setting(REG_IDX_NORMAL, 32'(cos_val));
    write_setting(REG_IDX_DIST, {1'b0, off_val});
  endtask

  task automatic run_random_items(input int n);
    logic        cmd;
    plane_t      p;
    int unsigned roll;
    for (int k = 0; k < n; k++) begin
      roll   = $urandom_range(0, 199);
      cmd    = CMD_OFFER;
      p.nx   = 16'($urandom());
      p.ny   = 16'($urandom());
      p.nz   = 16'($urandom());
      p.off  = $urandom();
      if (roll < clear_odds) begin
        cmd = CMD_CLEAR;
      end else if (roll >= 28) begin
        if (roll < 140 && recent_planes.size() != 0)
          p = nearby_plane(recent_planes[$urandom_range(0, recent_planes.size() - 1)]);
        else
          p = fresh_plane();
      end
      send_request(cmd, p);
      if (cmd == CMD_OFFER) begin
        recent_planes.push_back(p);
        if (recent_planes.size() > 48) void'(recent_planes.pop_front());
      end
    end
  endtask

  // Runs on the reset settings: field extremes, tolerance edges, clears
  task automatic test_field_extremes();
    send_request(CMD_OFFER, mk_plane(NRM_MAX, 16'sd0, 16'sd0, 32'sd0));
    send_request(CMD_OFFER, mk_plane(NRM_MAX, 16'sd0, 16'sd0, 32'sd0));
    send_request(CMD_OFFER, mk_plane(NRM_MAX, 16'sd0, 16'sd0, 32'sd25600));
    send_request(CMD_OFFER, mk_plane(NRM_MAX, 16'sd0, 16'sd0, -32'sd25599));
    send_request(CMD_OFFER, mk_plane(NRM_MIN, 16'sd0, 16'sd0, 32'sd0));
    send_request(CMD_OFFER, mk_plane(16'sd0, NRM_MAX, 16'sd0, OFF_MAX));
    send_request(CMD_OFFER, mk_plane(16'sd0, NRM_MAX, 16'sd0, OFF_MIN));
    // widest dot product, needs 33 signed bits
    send_request(CMD_OFFER, mk_plane(NRM_MIN, NRM_MIN, NRM_MIN, OFF_MIN));
    send_request(CMD_OFFER, mk_plane(NRM_MIN, NRM_MIN, NRM_MIN, OFF_MIN));
    send_request(CMD_CLEAR, mk_plane(16'shFFFF, 16'shFFFF, 16'shFFFF, 32'shFFFF_FFFF));
    send_request(CMD_OFFER, mk_plane(NRM_MAX, NRM_MAX, NRM_MAX, -32'sd1));
    send_request(CMD_OFFER, mk_plane(NRM_MAX, NRM_MAX, NRM_MAX, -32'sd256));
    send_request(CMD_CLEAR, mk_plane(16'sd0, 16'sd0, 16'sd0, 32'sd0));
  endtask

  task automatic test_threshold_edges();
    set_limits(16'sd16384, DIST_THR_RST);
    send_request(CMD_OFFER, mk_plane(NRM_MIN, 16'sd0, 16'sd0, 32'sd100));
    // dot equal to the limit does not match, one step past it does
    send_request(CMD_OFFER, mk_plane(-16'sd16384, 16'sd0, 16'sd0, 32'sd100));
    send_request(CMD_OFFER, mk_plane(-16'sd16385, 16'sd0, 16'sd0, 32'sd100));
    set_limits(16'sd16384, 31'd0);
    send_request(CMD_OFFER, mk_plane(NRM_MIN, 16'sd0, 16'sd0, 32'sd100));
    set_limits(NRM_MIN, DIST_MAX);
    send_request(CMD_OFFER, mk_plane(16'sd0, 16'sd0, NRM_MAX, OFF_MIN));
    send_request(CMD_OFFER, mk_plane(16'sd0, 16'sd0, NRM_MIN, 32'sh7FFF_FF00));
    set_limits(NRM_MAX, DIST_MAX);
    send_request(CMD_OFFER, mk_plane(NRM_MAX, 16'sd0, 16'sd0, 32'sd0));
    send_request(CMD_OFFER, mk_plane(NRM_MAX, 16'sd0, 16'sd0, 32'sd0));
    send_request(CMD_OFFER, mk_plane(NRM_MIN, NRM_MIN, 16'sd0, 32'sd0));
    send_request(CMD_OFFER, mk_plane(NRM_MIN, NRM_MIN, 16'sd0, 32'sd0));
  endtask

  task automatic test_table_full();
    plane_t filled[$];
    plane_t p;
    // zero tolerance: nothing matches, so every offer lands until the table is full
    set_limits(NORMAL_THR_RST, 31'd0);
    send_request(CMD_CLEAR, fresh_plane());
    for (int k = 0; k < TABLE_DEPTH + 2; k++) begin
      p = fresh_plane();
      send_request(CMD_OFFER, p);
      filled.push_back(p);
    end
    set_limits(NORMAL_THR_RST, DIST_THR_RST);
    send_request(CMD_OFFER, filled[$urandom_range(0, TABLE_DEPTH - 1)]);
    send_request(CMD_OFFER, nearby_plane(filled[$urandom_range(0, TABLE_DEPTH - 1)]));
    send_request(CMD_OFFER, fresh_plane());
    send_request(CMD_CLEAR, fresh_plane());
  endtask

  task automatic test_random_phases();
    logic signed [15:0] cos_pick;
    logic [30:0]        off_pick;
    for (int phase = 0; phase < 11; phase++) begin
      cos_pick = (phase % 2) ? 16'($urandom()) : 16'(32767 - $urandom_range(0, 8000));
      off_pick = 31'($urandom_range(0, 1 << $urandom_range(0, 24)));
      case (phase)
        0: set_limits(NRM_MIN, DIST_MAX);
        1: set_limits(NRM_MAX, 31'd0);
        2: set_limits(NORMAL_THR_RST, DIST_THR_RST);
        default: set_limits(cos_pick, off_pick);
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: clear_odds = 1;
        1: clear_odds = 3;
        default: clear_odds = 6;
      endcase
      run_random_items(110);
    end
  endtask

  task automatic test_steady_tail();
    set_limits(NORMAL_THR_RST, DIST_THR_RST);
    steady     = 1'b1;
    clear_odds = 3;
    run_random_items(200);
  endtask

  // Output stall: random bursts, occasional calm stretches, none in the tail
  always @(posedge clk_i) begin
    if (!rst_ni || steady) begin
      out_stall_i <= 1'b0;
    end else if (calm_left != 0) begin
      out_stall_i <= 1'b0;
      calm_left   <= calm_left - 1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) == 0) calm_left <= $urandom_range(100, 400);
      else if ($urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d, stored_count %0d",
               status_o, stored_count_o);
        fail_count++;
      end else begin
        due_result = pending_results.pop_front();
        if (status_o !== due_result.status) begin
          $error("status: expected %0d, got %0d", due_result.status, status_o);
          fail_count++;
        end
        if (stored_count_o !== due_result.count) begin
          $error("stored_count: expected %0d, got %0d", due_result.count, stored_count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_threshold_edges();
    test_table_full();
    test_random_phases();
    test_steady_tail();
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Checked %0d transactions: %0d added, %0d duplicates, %0d refused full, %0d clears",
             items_sent, status_tally[ST_ADDED], status_tally[ST_DUP],
             status_tally[ST_FULL], status_tally[ST_CLEARED]);
    $display("over %0d register writes, with random idling on both channels and a steady tail",
             reg_writes);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
